// ===== rtl/b64d_pkg.sv =====
// Package: shared types and character constants for the base64 stream decoder.
`timescale 1ns / 1ps
package b64d_pkg;

	// Character codes
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PAD     = 8'h3D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	// Sextet offsets for each symbol range
	localparam logic [5:0] OFS_LOWER = 6'd26;
	localparam logic [5:0] OFS_DIGIT = 6'd52;
	localparam logic [5:0] SYM_PLUS  = 6'd62;
	localparam logic [5:0] SYM_SLASH = 6'd63;

	// Last result index within a job
	localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
	localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
	localparam logic [1:0] LAST_IDX_THREE = 2'd2;

	// One queued job: up to three results released by a single input word
	typedef struct packed {
		logic [23:0] bytes;     // first result in the high byte
		logic [1:0]  last_idx;  // index of the final result of the job
		logic        data;      // 0 for a bare end marker
		logic        eos;       // job closes the text
	} b64d_job_t;

endpackage

// ===== rtl/b64d_front.sv =====
// Front end: classifies characters, accumulates sextets, builds output jobs.
`timescale 1ns / 1ps
module b64d_front
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       end_of_string,
	output logic       push,
	output b64d_job_t  push_job
);

	logic [1:0]  cnt_q;
	logic [17:0] held_q;
	logic        pad_q;

	logic        accept;
	logic        blank, is_pad, sym_ok, active, take, full_grp;
	logic [5:0]  sextet;
	logic [1:0]  cnt_n;
	logic [17:0] held_n;
	logic        pad_n;

	always_comb begin
		blank  = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
		is_pad = (char_code == CH_PAD);
		sym_ok = 1'b1;
		sextet = '0;
		if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
			sextet = 6'(char_code - CH_UPPER_A);
		end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
			sextet = 6'(char_code - CH_LOWER_A) + OFS_LOWER;
		end else if (char_code >= CH_DIGIT_0 && char_code <= CH_DIGIT_9) begin
			sextet = 6'(char_code - CH_DIGIT_0) + OFS_DIGIT;
		end else if (char_code == CH_PLUS) begin
			sextet = SYM_PLUS;
		end else if (char_code == CH_SLASH) begin
			sextet = SYM_SLASH;
		end else begin
			sym_ok = 1'b0;
		end
	end

	assign accept   = in_valid && !in_stall;
	assign active   = !pad_q && !blank;
	assign take     = active && !is_pad && sym_ok;
	assign full_grp = take && (cnt_q == 2'd3);

	always_comb begin
		cnt_n  = cnt_q;
		held_n = held_q;
		pad_n  = pad_q || (active && is_pad);
		if (full_grp) begin
			cnt_n  = '0;
			held_n = '0;
		end else if (take) begin
			cnt_n  = cnt_q + 2'd1;
			held_n = {held_q[11:0], sextet};
		end
	end

	// Job assembly: full group, then tail of a partial group, else bare marker
	always_comb begin
		push_job.bytes    = '0;
		push_job.last_idx = LAST_IDX_ONE;
		push_job.data     = 1'b1;
		push_job.eos      = end_of_string;
		if (full_grp) begin
			push_job.bytes    = {held_q, sextet};
			push_job.last_idx = LAST_IDX_THREE;
		end else if (cnt_n == 2'd2) begin
			push_job.bytes[23:16] = held_n[11:4];
		end else if (cnt_n == 2'd3) begin
			push_job.bytes[23:16] = held_n[17:10];
			push_job.bytes[15:8]  = held_n[9:2];
			push_job.last_idx     = LAST_IDX_TWO;
		end else begin
			push_job.data = 1'b0;
		end
	end

	assign push = accept && (full_grp || end_of_string);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			held_q <= '0;
			pad_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_string) begin
				cnt_q  <= '0;
				held_q <= '0;
				pad_q  <= 1'b0;
			end else begin
				cnt_q  <= cnt_n;
				held_q <= held_n;
				pad_q  <= pad_n;
			end
		end
	end

	// a padding character freezes the sextet count until the end of the text
	a_pad_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q && accept && !end_of_string |=> $stable(cnt_q) && pad_q)
		else $error("sextet count moved after padding");

endmodule

// ===== rtl/b64d_queue.sv =====
// Short job queue between front end and result sequencer.
`timescale 1ns / 1ps
module b64d_queue
	import b64d_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  b64d_job_t push_job,
	input  logic      pop,
	output b64d_job_t head_job,
	output logic      full,
	output logic      empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	b64d_job_t       slot_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == DEPTH_CNT);
	assign empty    = (count_q == '0);
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

// ===== rtl/b64d_back.sv =====
// Back end: steps through each queued job, one result word per cycle while out_stall is low.
`timescale 1ns / 1ps
module b64d_back
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  b64d_job_t  head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_value,
	output logic       byte_valid,
	output logic       last_of_run,
	output logic       end_of_stream
);

	b64d_job_t  job_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       fire, at_last;

	assign out_valid = busy_q;
	assign fire      = busy_q && !out_stall;
	assign at_last   = (idx_q == job_q.last_idx);
	assign pop       = !q_empty && (!busy_q || (fire && at_last));

	always_comb begin
		case (idx_q)
			2'd0:    byte_value = job_q.bytes[23:16];
			2'd1:    byte_value = job_q.bytes[15:8];
			default: byte_value = job_q.bytes[7:0];
		endcase
	end

	assign byte_valid    = job_q.data;
	assign last_of_run   = at_last;
	assign end_of_stream = at_last && job_q.eos;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire && at_last) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= job_q.last_idx)
		else $error("result index past end of job");

	a_marker_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> last_of_run && end_of_stream)
		else $error("bare marker not closing the text");

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// Top level: base64 stream decoder, front end, job queue and result sequencer.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------------------
//  input   | in        | in_valid / in_stall   | char_code[7:0], end_of_string
//  output  | out       | out_valid / out_stall | byte_value[7:0], byte_valid, last_of_run,
//          |           |                      | end_of_stream
//
//  One character word is taken per cycle while the job queue has room; each
//  character is classified and folded into the sextet register in its own cycle.
//  Results leave at one word per cycle while out_stall is low, each job passing a
//  queue slot and the sequencer register first. Four symbols give at most three
//  words, so the sustained rate is one character per cycle; the queue absorbs group bursts.
//  arst_n clears the sextet accumulator, the padding flag, the queue and the
//  sequencer. in_stall rises only when all QUEUE_DEPTH job slots are in use,
//  which takes out_stall holding results back.
//
module base64_stream_decoder
	import b64d_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_value,
	output logic       byte_valid,
	output logic       last_of_run,
	output logic       end_of_stream
);

	logic      push, pop, q_full, q_empty;
	b64d_job_t push_job, head_job;

	// input stalls only on a full queue: classification itself is combinational
	assign in_stall = q_full;

	// Front end: symbol decode, sextet accumulation, job assembly
	b64d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.push          (push),
		.push_job      (push_job)
	);

	// Decouples character intake from result delivery
	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back end: emits the one to three result words of each job
	b64d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head_job      (head_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.byte_value    (byte_value),
		.byte_valid    (byte_valid),
		.last_of_run   (last_of_run),
		.end_of_stream (end_of_stream)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for base64_stream_decoder: directed text, back-pressure, random text.
`timescale 1ns / 1ps

module testbench
	import b64d_pkg::*;
();

	// Run shape
	localparam int RANDOM_ITEMS   = 430;   // random part stops once this many words are accepted
	localparam int CALM_ITEMS     = 170;   // random part idles only once this many are taken
	localparam int IDLE_PCT       = 36;    // chance of an idle cycle on either side
	localparam int HOLD_CYCLES    = 80;    // long receiver hold-off, fills the job queue
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES   = 16;    // settle time after the last expected word

	// One output word, packed in port order
	typedef struct packed {
		logic [7:0] value;
		logic       has_data;
		logic       run_end;
		logic       stream_end;
	} dec_word_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] char_code;
	logic       end_of_string;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] byte_value;
	logic       byte_valid;
	logic       last_of_run;
	logic       end_of_stream;

	base64_stream_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_value   (byte_value),
		.byte_valid   (byte_valid),
		.last_of_run  (last_of_run),
		.end_of_stream(end_of_stream)
	);

	always #4 clk = ~clk;

	// Decoder state as predicted by the testbench
	logic [1:0]  held_cnt  = 2'd0;   // sextets waiting for a full group
	logic [17:0] held_bits = 18'd0;  // oldest sextet in the high bits
	logic        pad_seen  = 1'b0;   // '=' seen, rest of the text is dropped

	dec_word_t   expected_words[$];  // words still owed by the decoder, oldest first
	logic [7:0]  text_buf[$];        // text being assembled for the sender

	int  taken_items  = 0;   // accepted input words
	int  fail_count   = 0;
	int  quiet_cycles = 0;
	bit  tx_idle      = 1'b0;  // sender inserts random gaps
	bit  rx_idle      = 1'b0;  // receiver stalls at random
	logic hold_rx     = 1'b0;  // receiver hold-off in progress

	// Map 0..63 to its base64 character
	function automatic logic [7:0] symbol_char(input int unsigned v);
		if (v < OFS_LOWER)
			return CH_UPPER_A + 8'(v);
		if (v < OFS_DIGIT)
			return CH_LOWER_A + 8'(v - OFS_LOWER);
		if (v < SYM_PLUS)
			return CH_DIGIT_0 + 8'(v - OFS_DIGIT);
		return (v == SYM_PLUS) ? CH_PLUS : CH_SLASH;
	endfunction

	// Predict the words released by one accepted character and queue them
	function automatic void decode_char(input logic [7:0] ch, input logic eos);
		logic [7:0]  vals[3];
		logic [23:0] grp;
		logic        data;
		int          n;
		int          v;
		int          k;
		n      = 0;
		v      = -1;
		data   = 1'b1;
		// whitespace and anything after padding never reach the sextet path
		if (!pad_seen && ch != CH_SPACE && !(ch >= CH_TAB && ch <= CH_CR)) begin
			if (ch == CH_PAD) begin
				pad_seen = 1'b1;
			end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
				v = int'(ch - CH_UPPER_A);
			end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
				v = int'(ch - CH_LOWER_A) + int'(OFS_LOWER);
			end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
				v = int'(ch - CH_DIGIT_0) + int'(OFS_DIGIT);
			end else if (ch == CH_PLUS) begin
				v = int'(SYM_PLUS);
			end else if (ch == CH_SLASH) begin
				v = int'(SYM_SLASH);
			end
		end
		if (v >= 0) begin
			if (held_cnt == 2'd3) begin
				grp       = {held_bits, v[5:0]};
				vals[0]   = grp[23:16];
				vals[1]   = grp[15:8];
				vals[2]   = grp[7:0];
				n         = 3;
				held_cnt  = 2'd0;
				held_bits = 18'd0;
			end else begin
				held_bits = {held_bits[11:0], v[5:0]};
				held_cnt  = held_cnt + 2'd1;
			end
		end
		if (eos) begin
			// partial group of n sextets gives n-1 bytes
			if (held_cnt == 2'd2) begin
				vals[n] = held_bits[11:4];
				n       = n + 1;
			end else if (held_cnt == 2'd3) begin
				vals[n]     = held_bits[17:10];
				vals[n + 1] = held_bits[9:2];
				n           = n + 2;
			end
			// nothing released: bare end marker
			if (n == 0) begin
				vals[0] = 8'h00;
				data    = 1'b0;
				n       = 1;
			end
			held_cnt  = 2'd0;
			held_bits = 18'd0;
			pad_seen  = 1'b0;
		end
		for (k = 0; k < n; k++)
			expected_words.push_back({vals[k], data, k == n - 1, eos && k == n - 1});
		taken_items++;
	endfunction

	task automatic report_fail(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	// Monitor. Everything is driven at the rising edge, so the values seen at the
	// falling edge are the ones the next rising edge will act on. Input words are
	// predicted before output words are checked, so even a same-edge pass-through
	// would find its expectation already queued.
	always @(negedge clk) begin : monitor
		dec_word_t got;
		dec_word_t want;
		bit        in_fire;
		bit        out_fire;
		in_fire  = arst_n && in_valid && !in_stall;
		out_fire = arst_n && out_valid && !out_stall;
		if (in_fire)
			decode_char(char_code, end_of_string);
		if (out_fire) begin
			got = {byte_value, byte_valid, last_of_run, end_of_stream};
			if (expected_words.size() == 0) begin
				report_fail($sformatf("unexpected word: value=%02h valid=%0b last=%0b eos=%0b",
					got.value, got.has_data, got.run_end, got.stream_end));
			end else begin
				want = expected_words.pop_front();
				if (got.value !== want.value || got.has_data !== want.has_data ||
						got.run_end !== want.run_end || got.stream_end !== want.stream_end)
					report_fail($sformatf(
						"mismatch: exp val=%02h v=%0b l=%0b e=%0b, got val=%02h v=%0b l=%0b e=%0b",
						want.value, want.has_data, want.run_end, want.stream_end,
						got.value, got.has_data, got.run_end, got.stream_end));
			end
		end
		// watchdog: counts cycles in which no word moves on either side
		if (!arst_n || in_fire || out_fire) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", quiet_cycles);
				$display("[base64_stream_decoder] ERROR");
				$finish;
			end
		end
	end

	// Receiver: random stalls, or a solid stall while a hold-off runs
	always @(posedge clk)
		out_stall <= hold_rx || (rx_idle && $urandom_range(99) < IDLE_PCT);

	// Offer one character word and wait until it is taken. Called at a rising
	// edge; returns at the edge that accepted the word, valid still high.
	task automatic send_word(input logic [7:0] ch, input logic eos);
		while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		char_code     <= ch;
		end_of_string <= eos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic add_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	// Send the assembled text, end flag on its final character
	task automatic send_text_buf();
		int i;
		for (i = 0; i < text_buf.size(); i++)
			send_word(text_buf[i], i == text_buf.size() - 1);
		text_buf.delete();
	endtask

	// Range edges of every symbol class; ends on a full group (no marker)
	task automatic test_alphabet_edges();
		add_str("AZaz09+/");
		send_text_buf();
	endtask

	// Whitespace, high bytes and other junk are skipped; after '=' all is dropped
	// but the end flag on a dropped character still closes the text
	task automatic test_skipped_chars();
		text_buf.push_back(CH_SPACE);
		add_str("Q");
		text_buf.push_back(CH_TAB);
		text_buf.push_back(CH_CR);
		add_str("Q");
		text_buf.push_back(8'h80);
		text_buf.push_back(8'hFF);
		text_buf.push_back(8'h08);
		text_buf.push_back(CH_PAD);
		add_str("Z");
		text_buf.push_back(8'h0E);
		send_text_buf();
	endtask

	// Lone sextet at end gives only the marker; three give two bytes; junk-only text
	task automatic test_partial_groups();
		add_str("A");
		send_text_buf();
		add_str("AB/");
		send_text_buf();
		text_buf.push_back(8'h00);
		send_text_buf();
	endtask

	// Receiver holds off while dense text keeps coming: queue fills, input stalls
	task automatic test_backpressure();
		int t;
		int k;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		fork
			begin
				hold_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
		for (t = 0; t < 2; t++) begin
			for (k = 0; k < 16; k++)
				text_buf.push_back(symbol_char($urandom_range(63)));
			send_text_buf();
		end
	endtask

	// Mostly well-formed text with random content, some padding and junk after it,
	// plus lone noise words with a random end flag
	task automatic test_random_text();
		int nsym;
		int k;
		tx_idle     = 1'b0;
		rx_idle     = 1'b0;
		while (taken_items < RANDOM_ITEMS) begin
			if (taken_items >= CALM_ITEMS) begin
				tx_idle = 1'b1;
				rx_idle = 1'b1;
			end
			if ($urandom_range(99) < 15) begin
				send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
			end else begin
				// mostly short texts, now and then a long one
				nsym = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(11);
				for (k = 0; k < nsym; k++) begin
					if ($urandom_range(9) == 0)
						text_buf.push_back(($urandom_range(6) == 0) ? CH_SPACE :
							8'($urandom_range(CH_CR, CH_TAB)));
					text_buf.push_back(symbol_char($urandom_range(63)));
				end
				if ($urandom_range(1)) begin
					repeat ($urandom_range(2, 1)) text_buf.push_back(CH_PAD);
					repeat ($urandom_range(2)) text_buf.push_back($urandom_range(1) ?
						symbol_char($urandom_range(63)) : 8'($urandom_range(255)));
				end
				if (text_buf.size() == 0)
					text_buf.push_back(CH_SPACE);
				send_text_buf();
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		char_code     = 8'h00;
		end_of_string = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed tests run with idling on both sides, the back-pressure test apart
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		test_alphabet_edges();
		test_skipped_chars();
		test_partial_groups();
		test_backpressure();
		test_random_text();
		in_valid <= 1'b0;

		// drain: the watchdog bounds this wait
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[base64_stream_decoder] OK");
		else
			$display("[base64_stream_decoder] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
tb/testbench.sv
